// File: rtl/lbw_pkg.sv
// Package for the longest balanced window block: byte class constants and
// the control group passed from the balance stage to the result stage.
// No dependencies.
package lbw_pkg;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam int START_W  = 10;
   localparam int LENGTH_W = 11;

   // control of one transaction between the balance stage and the result stage
   typedef struct packed {
      logic valid;   // stage holds a transaction
      logic hit;     // balance seen before: a window ends here
      logic zero;    // balance is zero: window starts at position 0
      logic last;    // sequence ends with this transaction
      logic ovf;     // sequence has dropped an item
   } lbw_ctl_type;

endpackage

// File: rtl/longest_balanced_window.sv
// Channel  Direction  Handshake         Payload
// req      in         req_valid/stall   first_char[7:0], last_item
// rsp      out        rsp_valid/stall   best_start[9:0], best_length[10:0],
//                                       overflowed, is_final
// One transaction per cycle unless rsp_stall holds a response; both stages register it.
// The rate is set by the single table access per item, a write or a read; the seen
// range of balances is tracked in min/max registers, so no table clear is needed.
// Reset is synchronous.
// Both stages hold while a response waits under rsp_stall; req_stall follows.
// Top level; depends on lbw_pkg, lbw_front, lbw_best.
module longest_balanced_window #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_first_char,
   input  logic                           req_last_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lbw_pkg::START_W-1:0]    rsp_best_start,
   output logic [lbw_pkg::LENGTH_W-1:0]   rsp_best_length,
   output logic                           rsp_overflowed,
   output logic                           rsp_is_final
);
   import lbw_pkg::*;

   localparam int PW = $clog2(MAX_ITEMS + 1);

   logic          advance;
   lbw_ctl_type   ctl;
   logic [PW-1:0] pos, first_pos;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   lbw_front #(
      .MAX_ITEMS (MAX_ITEMS),
      .PW        (PW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req_valid      (req_valid),
      .req_first_char (req_first_char),
      .req_last_item  (req_last_item),
      .ctl            (ctl),
      .pos            (pos),
      .first_pos      (first_pos)
   );

   lbw_best #(
      .PW (PW)
   ) u_best (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .ctl             (ctl),
      .pos             (pos),
      .first_pos       (first_pos),
      .rsp_valid       (rsp_valid),
      .rsp_best_start  (rsp_best_start),
      .rsp_best_length (rsp_best_length),
      .rsp_overflowed  (rsp_overflowed),
      .rsp_is_final    (rsp_is_final)
   );

endmodule

// File: rtl/lbw_table.sv
// First-seen position table: one write port, one read port, registered
// read data that holds while no read is issued.
// No dependencies.
module lbw_table #(
   parameter int DEPTH = 2049,
   parameter int AW    = 12,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lbw_front.sv
// Balance stage: running balance, position, seen-balance range and the
// first-seen table access for each accepted transaction.
// Depends on lbw_pkg and lbw_table.
module lbw_front #(
   parameter int MAX_ITEMS = 1024,
   parameter int PW        = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 req_valid,
   input  logic [7:0]           req_first_char,
   input  logic                 req_last_item,
   output lbw_pkg::lbw_ctl_type ctl,
   output logic [PW-1:0]        pos,
   output logic [PW-1:0]        first_pos
);
   import lbw_pkg::*;

   localparam int BW    = PW + 1;
   localparam int DEPTH = 2 * MAX_ITEMS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [PW-1:0]        MAX_POS = PW'(MAX_ITEMS);
   localparam logic [BW-1:0]        OFFSET  = BW'(MAX_ITEMS);
   localparam logic signed [BW-1:0] ONE     = BW'(1);

   logic signed [BW-1:0] bal_ff, bal_in, min_ff, min_in, max_ff, max_in;
   logic [PW-1:0]        pos_ff, pos_in, s1_pos_ff, s1_pos_in;
   logic                 ovf_ff, ovf_in;
   lbw_ctl_type          ctl_ff, ctl_in;

   logic                 accept, digit, full, grow_hi, grow_lo, fresh;
   logic signed [BW-1:0] bal_step;
   logic [PW-1:0]        pos_step;
   logic [AW-1:0]        slot;
   logic                 wr_en, rd_en;

   always_comb begin
      accept   = advance && req_valid;
      digit    = (req_first_char >= CHAR_ZERO) && (req_first_char <= CHAR_NINE);
      bal_step = digit ? bal_ff + ONE : bal_ff - ONE;
      pos_step = pos_ff + PW'(1);
      full     = pos_ff >= MAX_POS;
      // balance moves by one, so the seen balances always form [min, max]
      grow_hi  = bal_step > max_ff;
      grow_lo  = bal_step < min_ff;
      fresh    = grow_hi || grow_lo;
      slot     = AW'($unsigned(bal_step) + OFFSET);

      bal_in    = bal_ff;
      pos_in    = pos_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      ovf_in    = ovf_ff;
      ctl_in    = ctl_ff;
      s1_pos_in = s1_pos_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;

      if (advance) begin
         ctl_in = '0;
      end
      if (accept) begin
         ctl_in.valid = 1'b1;
         ctl_in.last  = req_last_item;
         ctl_in.ovf   = full || ovf_ff;
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            bal_in      = bal_step;
            pos_in      = pos_step;
            s1_pos_in   = pos_step;
            if (grow_hi) max_in = bal_step;
            if (grow_lo) min_in = bal_step;
            wr_en       = fresh;
            ctl_in.hit  = !fresh;
            ctl_in.zero = (bal_step == '0);
            // balance zero is preset at position 0 and never stored
            rd_en       = !fresh && (bal_step != '0);
         end
         if (req_last_item) begin
            bal_in = '0;
            pos_in = '0;
            min_in = '0;
            max_in = '0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bal_ff <= '0;
         pos_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
         ovf_ff <= 1'b0;
         ctl_ff <= '0;
      end else begin
         bal_ff <= bal_in;
         pos_ff <= pos_in;
         min_ff <= min_in;
         max_ff <= max_in;
         ovf_ff <= ovf_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff <= s1_pos_in;
   end

   lbw_table #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (PW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (pos_step),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (first_pos)
   );

   assign ctl = ctl_ff;
   assign pos = s1_pos_ff;

endmodule

// File: rtl/lbw_best.sv
// Result stage: window length check against the held best window and the
// response register.
// Depends on lbw_pkg.
module lbw_best #(
   parameter int PW = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  lbw_pkg::lbw_ctl_type           ctl,
   input  logic [PW-1:0]                  pos,
   input  logic [PW-1:0]                  first_pos,
   output logic                           rsp_valid,
   output logic [lbw_pkg::START_W-1:0]    rsp_best_start,
   output logic [lbw_pkg::LENGTH_W-1:0]   rsp_best_length,
   output logic                           rsp_overflowed,
   output logic                           rsp_is_final
);
   import lbw_pkg::*;

   logic [PW-1:0]       best_start_ff, best_start_in, best_len_ff, best_len_in;
   logic [PW-1:0]       first, len, new_start, new_len;
   logic                take;
   logic                valid_ff, valid_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic                ovf_ff, ovf_in, final_ff, final_in;

   always_comb begin
      first     = ctl.zero ? '0 : first_pos;
      len       = pos - first;
      // strictly longer only: ties keep the earlier window
      take      = ctl.hit && (len > best_len_ff);
      new_len   = take ? len : best_len_ff;
      new_start = take ? first : best_start_ff;

      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      valid_in      = valid_ff;
      start_in      = start_ff;
      length_in     = length_ff;
      ovf_in        = ovf_ff;
      final_in      = final_ff;

      if (advance) begin
         valid_in = ctl.valid;
         if (ctl.valid) begin
            start_in      = START_W'(new_start);
            length_in     = LENGTH_W'(new_len);
            ovf_in        = ctl.ovf;
            final_in      = ctl.last;
            best_start_in = ctl.last ? '0 : new_start;
            best_len_in   = ctl.last ? '0 : new_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_start_ff <= '0;
         best_len_ff   <= '0;
         valid_ff      <= 1'b0;
      end else begin
         best_start_ff <= best_start_in;
         best_len_ff   <= best_len_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      length_ff <= length_in;
      ovf_ff    <= ovf_in;
      final_ff  <= final_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_best_start  = start_ff;
   assign rsp_best_length = length_ff;
   assign rsp_overflowed  = ovf_ff;
   assign rsp_is_final    = final_ff;

endmodule

// File: rtl/lbw_checker.sv
// Port-level checks for longest_balanced_window, bound to the top level.
// Depends on lbw_pkg and the top level's port list.
module lbw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [lbw_pkg::START_W-1:0]    rsp_best_start,
   input logic [lbw_pkg::LENGTH_W-1:0]   rsp_best_length,
   input logic                           rsp_overflowed,
   input logic                           rsp_is_final
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a balanced window holds as many digits as letters
   a_even_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_best_length[0])
      else $error("odd window length");

   a_none_at_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_best_length == '0)) |-> (rsp_best_start == '0))
      else $error("start reported without a window");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while response held");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_best_start)
         && $stable(rsp_best_length) && $stable(rsp_overflowed)
         && $stable(rsp_is_final)))
      else $error("stalled response changed");

endmodule

bind longest_balanced_window lbw_checker u_lbw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_best_start  (rsp_best_start),
   .rsp_best_length (rsp_best_length),
   .rsp_overflowed  (rsp_overflowed),
   .rsp_is_final    (rsp_is_final)
);

// File: tb/tb_longest_balanced_window.sv
// Self-checking testbench for longest_balanced_window: a queue-fed driver, a
// monitor and a digit/letter prefix-balance predictor of the window search.
// Depends on lbw_pkg and the longest_balanced_window RTL.
`timescale 1ns / 1ps

module tb_longest_balanced_window;
   import lbw_pkg::*;

   localparam int MAX_ITEMS   = 1024;
   localparam int TABLE_DEPTH = 2 * MAX_ITEMS + 1;
   localparam int QUIET_TAIL  = 150;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   typedef struct packed {
      logic [START_W-1:0]  best_start;
      logic [LENGTH_W-1:0] best_length;
      logic                overflowed;
      logic                is_final;
   } window_rsp_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [7:0]          req_first_char = 8'h00;
   logic                req_last_item  = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [START_W-1:0]  rsp_best_start;
   logic [LENGTH_W-1:0] rsp_best_length;
   logic                rsp_overflowed;
   logic                rsp_is_final;

   char_item_type  item_q[$];
   window_rsp_type window_q[$];

   // predictor state
   logic signed [11:0]  bal;
   logic [10:0]         pos;
   logic                seen_ok [0:TABLE_DEPTH-1];
   logic [10:0]         seen_at [0:TABLE_DEPTH-1];
   logic [START_W-1:0]  win_start;
   logic [LENGTH_W-1:0] win_len;
   logic                dropped;

   int  total_items;
   int  sent_cnt  = 0;
   int  seq_cnt   = 0;
   int  rsp_cnt   = 0;
   int  ovf_cnt   = 0;
   int  err_cnt   = 0;
   int  gap_left  = 0;
   int  stall_left = 0;
   logic quiet    = 1'b0;
   logic calm     = 1'b0;
   char_item_type  nxt;
   window_rsp_type got;
   window_rsp_type want;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   longest_balanced_window #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_first_char (req_first_char),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_start (rsp_best_start),
      .rsp_best_length(rsp_best_length),
      .rsp_overflowed (rsp_overflowed),
      .rsp_is_final   (rsp_is_final)
   );

   task automatic clear_window_state();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         seen_ok[i] = 1'b0;
         seen_at[i] = '0;
      end
      seen_ok[MAX_ITEMS] = 1'b1;
      bal       = '0;
      pos       = '0;
      win_start = '0;
      win_len   = '0;
      dropped   = 1'b0;
   endtask

   task automatic predict_window(input logic [7:0] ch, input logic last);
      int             slot;
      logic [10:0]    span;
      window_rsp_type r;
      if (pos >= MAX_ITEMS) begin
         dropped = 1'b1;
      end else begin
         bal  = (ch >= CHAR_ZERO && ch <= CHAR_NINE) ? bal + 12'sd1 : bal - 12'sd1;
         pos  = pos + 11'd1;
         slot = int'(bal) + MAX_ITEMS;
         if (seen_ok[slot]) begin
            span = pos - seen_at[slot];
            // strictly longer only: earliest of equal windows stays
            if (span > win_len) begin
               win_len   = span;
               win_start = seen_at[slot][START_W-1:0];
            end
         end else begin
            seen_ok[slot] = 1'b1;
            seen_at[slot] = pos;
         end
      end
      r.best_start  = win_start;
      r.best_length = win_len;
      r.overflowed  = dropped;
      r.is_final    = last;
      window_q.push_back(r);
      if (last)
         clear_window_state();
   endtask

   task automatic add_item(input logic [7:0] ch, input logic last);
      char_item_type it;
      it.ch   = ch;
      it.last = last;
      item_q.push_back(it);
   endtask

   task automatic add_run(input logic [7:0] ch, input int n, input logic end_here);
      for (int i = 0; i < n; i++)
         add_item(ch, end_here && (i == n - 1));
   endtask

   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c = CHAR_ZERO + 8'($urandom_range(0, 9));
         4, 5, 6, 7: begin
            c = 8'($urandom_range(0, 255));
            while (c >= CHAR_ZERO && c <= CHAR_NINE)
               c = 8'($urandom_range(0, 255));
         end
         8: case ($urandom_range(0, 3))
               0: c = 8'h00;
               1: c = CHAR_ZERO - 8'd1;
               2: c = CHAR_NINE + 8'd1;
               default: c = 8'hFF;
            endcase
         default: c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   task automatic add_random_seqs(input int n_items);
      int cnt;
      int len;
      cnt = 0;
      while (cnt < n_items) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
         for (int i = 0; i < len; i++)
            add_item(pick_char(), i == len - 1);
         cnt += len;
      end
   endtask

   // driver: holds payload while stalled, random gap bursts between transactions
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_window(req_first_char, req_last_item);
            sent_cnt++;
            if (req_last_item)
               seq_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (item_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else begin
               nxt = item_q.pop_front();
               req_valid      <= 1'b1;
               req_first_char <= nxt.ch;
               req_last_item  <= nxt.last;
            end
         end
         quiet <= (item_q.size() < QUIET_TAIL);
         if ($urandom_range(0, 63) == 0)
            calm <= !calm;
      end
   end

   // monitor: compares each response transaction with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.best_start  = rsp_best_start;
            got.best_length = rsp_best_length;
            got.overflowed  = rsp_overflowed;
            got.is_final    = rsp_is_final;
            rsp_cnt++;
            if (rsp_overflowed === 1'b1)
               ovf_cnt++;
            if (window_q.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("[%0t] unexpected response start=%0d len=%0d ovf=%b fin=%b",
                           $realtime, got.best_start, got.best_length, got.overflowed,
                           got.is_final);
            end else begin
               want = window_q.pop_front();
               if (got !== want) begin
                  err_cnt++;
                  if (err_cnt <= 10) begin
                     $display("[%0t] response %0d mismatch: expected start=%0d len=%0d ovf=%b fin=%b",
                              $realtime, rsp_cnt, want.best_start, want.best_length,
                              want.overflowed, want.is_final);
                     $display("      got start=%0d len=%0d ovf=%b fin=%b",
                              got.best_start, got.best_length, got.overflowed,
                              got.is_final);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      clear_window_state();

      // directed: lone final element, digit/letter borders, no-window and tie cases
      add_item(8'h00, 1'b1);
      add_item(CHAR_ZERO, 1'b0);
      add_item(CHAR_ZERO - 8'd1, 1'b0);
      add_item(CHAR_NINE, 1'b0);
      add_item(CHAR_NINE + 8'd1, 1'b1);
      add_item(8'h00, 1'b0);
      add_item(8'hFF, 1'b0);
      add_item(8'h7F, 1'b1);
      add_item(8'h35, 1'b0);
      add_item(8'h61, 1'b0);
      add_item(8'h62, 1'b0);
      add_item(8'h36, 1'b0);
      add_item(8'h37, 1'b0);
      add_item(8'h63, 1'b0);
      add_item(8'h80, 1'b1);
      add_item(CHAR_NINE, 1'b1);
      add_item(8'h41, 1'b0);
      add_item(8'h31, 1'b0);
      add_item(8'h42, 1'b0);
      add_item(8'h32, 1'b1);

      // long digit run, late window start
      add_run(8'h35, 150, 1'b0);
      add_item(8'h78, 1'b0);
      add_item(8'h31, 1'b0);
      add_item(8'h7A, 1'b1);
      // whole sequence is one balanced window
      add_run(CHAR_NINE, 100, 1'b0);
      add_run(8'h41, 100, 1'b1);
      // letters only, deep negative balance, no window
      add_run(8'h61, 60, 1'b1);
      add_random_seqs(420);
      total_items = item_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (sent_cnt < total_items)
         @(posedge clock);
      while (window_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d responses for %0d requests over %0d sequences.",
               rsp_cnt, sent_cnt, seq_cnt);
      $display("Responses with overflow flagged: %0d; mismatches: %0d.", ovf_cnt, err_cnt);
      if (err_cnt == 0 && window_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
